### src/sme_pkg.sv
// shared types, opcodes and constants of the stack machine execute block
package sme_pkg;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned WordBits   = 32;

  // opcodes carried in the mode field
  typedef enum logic [3:0] {
    OP_ERR   = 4'd0,
    OP_HALT  = 4'd1,
    OP_PUSH  = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_MOD   = 4'd7,
    OP_POW   = 4'd8,
    OP_ROOT  = 4'd9,
    OP_JUMP  = 4'd10,
    OP_JIF   = 4'd11,
    OP_PRINT = 4'd12
  } sme_op_e;

  // error codes of a result beat
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrOpcode    = 3'd1;
  localparam logic [2:0] ErrUnknown   = 3'd2;
  localparam logic [2:0] ErrUnderflow = 3'd3;
  localparam logic [2:0] ErrOverflow  = 3'd4;
  localparam logic [2:0] ErrDivZero   = 3'd5;
  localparam logic [2:0] ErrBadRoot   = 3'd6;

  // operations of the iterative unit
  typedef enum logic [1:0] {
    ALU_DIV,
    ALU_MOD,
    ALU_POW,
    ALU_ROOT
  } sme_alu_op_e;

  typedef struct packed {
    logic [3:0]                 mode;
    logic signed [WordBits-1:0] immediate;
    logic [15:0]                word_index;
    logic                       program_start;
  } sme_in_t;

  typedef struct packed {
    logic [16:0]                next_index;
    logic                       print_valid;
    logic signed [WordBits-1:0] print_value;
    logic                       halt_seen;
    logic [2:0]                 error_code;
    logic signed [WordBits-1:0] error_value;
  } sme_out_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic alu_start;
    logic commit;
    logic out_load;
  } sme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_alu;
    logic alu_done;
    logic out_free;
  } sme_sts_t;

endpackage

### src/sme_alu.sv
// iterative unit: divide, modulo, power and integer root
module sme_alu (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  sme_pkg::sme_alu_op_e         op_i,
  input  logic [sme_pkg::WordBits-1:0] a_i,
  input  logic [sme_pkg::WordBits-1:0] b_i,
  output logic                         done_o,
  output logic [sme_pkg::WordBits-1:0] result_o
);
  import sme_pkg::*;

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_POW,
    A_ROOT
  } alu_state_e;

  alu_state_e        state_q;
  sme_alu_op_e       op_q;
  logic              neg_q;
  logic              done_q;
  logic [31:0]       res_q;
  logic [31:0]       acc_q;
  logic [31:0]       wrk_q;
  logic [31:0]       arg_q;
  logic [4:0]        cnt_q;
  logic [30:0]       rt_x_q;
  logic [4:0]        rt_n_q;
  logic [15:0]       rt_r_q;
  logic [3:0]        rt_bit_q;
  logic [4:0]        rt_k_q;
  logic [30:0]       rt_p_q;

  logic [31:0]       mag_a;
  logic [31:0]       mag_b;
  logic [32:0]       div_trial;
  logic              div_ge;
  logic [31:0]       div_rem_d;
  logic [31:0]       div_quo_d;
  logic [31:0]       div_sel;
  logic [31:0]       pow_acc_d;
  logic [31:0]       pow_base_d;
  logic [15:0]       rt_cand;
  logic [46:0]       rt_prod;
  logic              rt_fail;
  logic              rt_hit;

  // magnitudes for the divider
  assign mag_a = a_i[31] ? 32'(-a_i) : a_i;
  assign mag_b = b_i[31] ? 32'(-b_i) : b_i;

  // one restoring divide step
  always_comb begin
    div_trial = {acc_q, wrk_q[31]};
    div_ge    = div_trial >= {1'b0, arg_q};
    div_rem_d = div_ge ? 32'(div_trial - {1'b0, arg_q}) : div_trial[31:0];
    div_quo_d = {wrk_q[30:0], div_ge};
    div_sel   = (op_q == ALU_DIV) ? div_quo_d : div_rem_d;
  end

  // one square-and-multiply step, low word kept
  assign pow_acc_d  = 32'(acc_q * wrk_q);
  assign pow_base_d = 32'(wrk_q * wrk_q);

  // one trial multiply of the root search
  always_comb begin
    rt_cand = rt_r_q | (16'd1 << rt_bit_q);
    rt_prod = 47'(rt_p_q) * 47'(rt_cand);
    rt_fail = rt_prod > 47'(rt_x_q);
    rt_hit  = (rt_k_q + 5'd1) == rt_n_q;
  end

  // sequencer and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (start_i) begin
            op_q     <= op_i;
            cnt_q    <= '0;
            rt_x_q   <= a_i[30:0];
            rt_n_q   <= b_i[4:0];
            rt_r_q   <= '0;
            rt_bit_q <= 4'd15;
            rt_k_q   <= '0;
            rt_p_q   <= 31'd1;
            case (op_i)
              ALU_DIV, ALU_MOD: begin
                acc_q   <= '0;
                wrk_q   <= mag_a;
                arg_q   <= mag_b;
                neg_q   <= (op_i == ALU_DIV) ? (a_i[31] ^ b_i[31]) : a_i[31];
                state_q <= A_DIV;
              end
              ALU_POW: begin
                acc_q   <= 32'd1;
                wrk_q   <= a_i;
                arg_q   <= b_i;
                neg_q   <= 1'b0;
                state_q <= A_POW;
              end
              default: begin
                neg_q   <= 1'b0;
                state_q <= A_ROOT;
              end
            endcase
          end
        end
        A_DIV: begin
          acc_q <= div_rem_d;
          wrk_q <= div_quo_d;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            res_q   <= neg_q ? 32'(-div_sel) : div_sel;
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end
        end
        A_POW: begin
          if (arg_q == '0) begin
            res_q   <= acc_q;
            done_q  <= 1'b1;
            state_q <= A_IDLE;
          end else begin
            if (arg_q[0]) begin
              acc_q <= pow_acc_d;
            end
            wrk_q <= pow_base_d;
            arg_q <= {1'b0, arg_q[31:1]};
          end
        end
        A_ROOT: begin
          if (!rt_fail && !rt_hit) begin
            rt_p_q <= rt_prod[30:0];
            rt_k_q <= rt_k_q + 5'd1;
          end else begin
            // candidate settled, move to the next lower bit
            if (!rt_fail) begin
              rt_r_q <= rt_cand;
            end
            if (rt_bit_q == 4'd0) begin
              res_q   <= {16'd0, (rt_fail ? rt_r_q : rt_cand)};
              done_q  <= 1'b1;
              state_q <= A_IDLE;
            end else begin
              rt_bit_q <= rt_bit_q - 4'd1;
              rt_p_q   <= 31'd1;
              rt_k_q   <= '0;
            end
          end
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

### src/sme_ctrl.sv
// controller state machine of the stack machine execute block
module sme_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sme_pkg::sme_sts_t sts_i,
  output sme_pkg::sme_cmd_t cmd_o
);
  import sme_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RUN,
    S_DONE
  } ctrl_state_e;

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  sme_cmd_t    cmd;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts_i.need_alu) begin
          cmd.alu_start = 1'b1;
          state_d       = S_RUN;
        end else begin
          cmd.commit = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_RUN: begin
        if (sts_i.alu_done) begin
          cmd.commit = 1'b1;
          state_d    = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o      = cmd;

endmodule

### src/sme_datapath.sv
// datapath: stack memory, top-of-stack register, decode and result register
module sme_datapath #(
  parameter int unsigned StackDepth = sme_pkg::StackDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sme_pkg::sme_in_t  in_data_i,
  input  logic              cfg_valid_i,
  input  logic [31:0]       cfg_data_i,
  input  sme_pkg::sme_cmd_t cmd_i,
  output sme_pkg::sme_sts_t sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sme_pkg::sme_out_t out_data_o
);
  import sme_pkg::*;

  localparam int unsigned SpW = $clog2(StackDepth);

  logic [31:0]     mem [StackDepth];
  logic [31:0]     rd_q;
  logic [SpW-1:0]  sp_q;
  logic [SpW-1:0]  sp_eff;
  logic [31:0]     tos_q;
  logic [31:0]     marker_q;
  logic [3:0]      mode_q;
  logic [31:0]     imm_q;
  logic [15:0]     widx_q;
  sme_out_t        res_q;
  sme_out_t        out_q;
  logic            out_valid_q;

  logic [31:0]     op_a;
  logic [31:0]     op_b;
  logic [16:0]     nxt;
  logic [2:0]      err;
  logic            pv;
  logic            halt;
  logic [31:0]     errval;
  logic [31:0]     word;
  logic            is_binary;
  logic            do_push;
  logic            do_pop;
  logic            need_alu;
  sme_alu_op_e     alu_op;
  logic            alu_done;
  logic [31:0]     alu_res;
  logic [31:0]     res_word;

  assign op_a   = rd_q;
  assign op_b   = tos_q;
  assign sp_eff = in_data_i.program_start ? '0 : sp_q;

  // instruction decode and combinational results
  always_comb begin
    nxt       = 17'(widx_q) + 17'd1;
    err       = ErrNone;
    pv        = 1'b0;
    halt      = 1'b0;
    errval    = '0;
    word      = '0;
    is_binary = 1'b0;
    do_push   = 1'b0;
    need_alu  = 1'b0;
    alu_op    = ALU_DIV;
    case (mode_q)
      OP_ERR: begin
        err    = ErrOpcode;
        errval = imm_q;
        nxt    = 17'(widx_q) + 17'd2;
      end
      OP_HALT: halt = 1'b1;
      OP_PUSH: begin
        nxt = 17'(widx_q) + 17'd2;
        if (sp_q >= SpW'(StackDepth - 1)) begin
          err = ErrOverflow;
        end else begin
          do_push = 1'b1;
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW, OP_ROOT: begin
        is_binary = 1'b1;
        if (sp_q == '0) begin
          err = ErrUnderflow;
        end else begin
          case (mode_q)
            OP_ADD: word = op_a + op_b;
            OP_SUB: word = op_a - op_b;
            OP_MUL: word = 32'(op_a * op_b);
            OP_DIV, OP_MOD: begin
              if (op_b == '0) begin
                err = ErrDivZero;
              end else begin
                need_alu = 1'b1;
                alu_op   = (mode_q == OP_DIV) ? ALU_DIV : ALU_MOD;
              end
            end
            OP_POW: begin
              if (!op_b[31]) begin
                need_alu = 1'b1;
                alu_op   = ALU_POW;
              end else if (op_a == 32'd1) begin
                word = 32'd1;
              end else if (op_a == '1) begin
                word = op_b[0] ? '1 : 32'd1;
              end else if (op_a == '0) begin
                err = ErrDivZero;
              end else begin
                word = '0;
              end
            end
            default: begin
              // integer root, exponent on top
              if (op_b[31] || op_b == '0 || op_a[31]) begin
                err = ErrBadRoot;
              end else if (op_b == 32'd1) begin
                word = op_a;
              end else if (op_b[30:5] != '0) begin
                word = (op_a != '0) ? 32'd1 : 32'd0;
              end else begin
                need_alu = 1'b1;
                alu_op   = ALU_ROOT;
              end
            end
          endcase
        end
      end
      OP_JUMP: nxt = 17'(imm_q[15:0]) + 17'd1;
      OP_JIF: begin
        if (imm_q != '0) begin
          nxt = 17'(imm_q[15:0]) + 17'd1;
        end else begin
          nxt = 17'(widx_q) + 17'd2;
        end
      end
      OP_PRINT: pv = 1'b1;
      default: err = ErrUnknown;
    endcase
    do_pop   = is_binary && (err == ErrNone);
    res_word = need_alu ? alu_res : word;
  end

  // iterative arithmetic unit
  sme_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.alu_start),
    .op_i     (alu_op),
    .a_i      (op_a),
    .b_i      (op_b),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  // stack memory: operand read on accept, spill on push
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rd_q <= mem[sp_eff - SpW'(1)];
    end
    if (cmd_i.commit && do_push) begin
      mem[sp_q] <= tos_q;
    end
  end

  // marker, stack pointer and top of stack
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      marker_q <= '0;
      sp_q     <= '0;
      tos_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        marker_q <= cfg_data_i;
      end
      if (cmd_i.accept && in_data_i.program_start) begin
        sp_q  <= '0;
        tos_q <= marker_q;
      end else if (cmd_i.commit && do_push) begin
        sp_q  <= sp_q + SpW'(1);
        tos_q <= imm_q;
      end else if (cmd_i.commit && do_pop) begin
        sp_q  <= sp_q - SpW'(1);
        tos_q <= res_word;
      end
    end
  end

  // item and pending result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q <= in_data_i.mode;
      imm_q  <= in_data_i.immediate;
      widx_q <= in_data_i.word_index;
    end
    if (cmd_i.commit) begin
      res_q.next_index  <= nxt;
      res_q.print_valid <= pv;
      res_q.print_value <= pv ? tos_q : '0;
      res_q.halt_seen   <= halt;
      res_q.error_code  <= err;
      res_q.error_value <= errval;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.need_alu = need_alu;
  assign sts_o.alu_done = alu_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

### src/stack_machine_execute.sv
// top level of the stack machine execute block
//
// One input beat carries one instruction: opcode, the following word,
// the opcode's program position and a program start flag that empties
// the stack to the bottom marker before the instruction runs. One output
// beat answers each input beat with the next fetch position, a printed
// top value, halt and error reports.
// The configuration channel writes the bottom marker; it is always ready.
// The user must write it only while no instruction is in flight; the
// block itself does not enforce this. Push, add, sub, mul, print, jumps,
// halt and every error pass from idle through execute and done back to
// idle, and a new beat is taken only in the idle state. Divide and
// modulo run 32 steps in the iterative unit. Power runs one step per
// exponent bit. Root tries 16 result bits with up to n multiplies each,
// for exponents n from 2 to 31.
// Only one instruction is in flight; the output register lets the next
// beat enter while the last result waits. A stalled receiver holds the
// block in its done state until the output register frees.
// Reset empties the stack to a zero marker and clears the marker.
module stack_machine_execute #(
  parameter int unsigned StackDepth = sme_pkg::StackDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sme_pkg::sme_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sme_pkg::sme_out_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [31:0]       cfg_data_i
);
  import sme_pkg::*;

  sme_cmd_t cmd;
  sme_sts_t sts;

  // controller
  sme_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  sme_datapath #(
    .StackDepth (StackDepth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  assign cfg_ready_o = 1'b1;

endmodule

### src/sme_checker.sv
// port-level checks of the stack machine execute block, bound to the top
module sme_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input sme_pkg::sme_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input sme_pkg::sme_out_t out_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o,
  input logic [31:0]       cfg_data_i
);
  import sme_pkg::*;

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat changed while stalled");

  // one instruction in flight: no beat right after an accepted one
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an instruction is in flight");

  // a print beat never carries an error
  a_print_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.print_valid |-> out_data_o.error_code == ErrNone)
    else $error("print with an error code");

  // halt never comes with a print or an error
  a_halt_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.halt_seen |->
      !out_data_o.print_valid && out_data_o.error_code == ErrNone)
    else $error("halt beat with print or error");

endmodule

bind stack_machine_execute sme_checker u_sme_checker (.*);
